>>> rtl/core/mmts_pkg.sv
// Shared types and constants for the min/max tracking stack.
// Holds action and status codes, the stored entry type and the
// command/status structs between controller and datapath. No dependencies.
package mmts_pkg;

  // Action codes on the input word (code 3 behaves as a read)
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Status codes on the result word
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STS_UNDERFLOW = 2'd2;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEPTH_W = 8;

  // Reported for top, min and max when the stack is empty
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

  // One stack entry: value plus running min/max at or below it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] min;
    logic signed [DATA_W-1:0] max;
  } entry_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       push;      // write new entry, count up
    logic       pop;       // count down
    logic       fill;      // load top cache from memory read data
    logic       out_load;  // capture result word into output register
    logic [1:0] status;    // status code captured with the result
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic two_plus;        // at least two entries held
  } sts_t;

endpackage

>>> rtl/core/mmts_ctrl.sv
// Controller for the min/max tracking stack: handshake, action decode and
// the refill sequence after a pop. Depends on mmts_pkg.
module mmts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mmts_pkg::sts_t     sts_i,
  output mmts_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // Output register is free when empty or drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Action decode and sequencing
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = mmts_pkg::STS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (action_i == mmts_pkg::ACT_PUSH) begin
            cmd_o.out_load = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = mmts_pkg::STS_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (action_i == mmts_pkg::ACT_POP) begin
            if (sts_i.empty) begin
              cmd_o.out_load = 1'b1;
              cmd_o.status   = mmts_pkg::STS_UNDERFLOW;
            end else if (sts_i.two_plus) begin
              // new top lives in memory: read it next cycle
              cmd_o.pop = 1'b1;
              state_d   = ST_FETCH;
            end else begin
              cmd_o.pop      = 1'b1;
              cmd_o.out_load = 1'b1;
            end
          end else begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fill     = 1'b1;
        cmd_o.out_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/mmts_dp.sv
// Datapath for the min/max tracking stack: entry memory, top-of-stack cache,
// entry count and the result register. Depends on mmts_pkg.
module mmts_dp #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mmts_pkg::cmd_t                       cmd_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]   value_i,
  output mmts_pkg::sts_t                       sts_o,
  output logic signed [mmts_pkg::DATA_W-1:0]   top_value_o,
  output logic signed [mmts_pkg::DATA_W-1:0]   min_value_o,
  output logic signed [mmts_pkg::DATA_W-1:0]   max_value_o,
  output logic                                 is_empty_o,
  output logic [mmts_pkg::DEPTH_W-1:0]         depth_now_o,
  output logic [1:0]                           status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  mmts_pkg::entry_t mem [STACK_DEPTH];
  mmts_pkg::entry_t rd_q;
  mmts_pkg::entry_t cache_q, cache_d;
  mmts_pkg::entry_t new_entry;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m2;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             empty_d;

  // Status to controller
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.full     = (cnt_q == CW'(STACK_DEPTH));
  assign sts_o.two_plus = (cnt_q >= CW'(2));

  // Entry built on push; cache holds the current top when not empty
  always_comb begin
    new_entry.value = value_i;
    new_entry.min   = value_i;
    new_entry.max   = value_i;
    if (!sts_o.empty) begin
      if (cache_q.min < value_i) new_entry.min = cache_q.min;
      if (cache_q.max > value_i) new_entry.max = cache_q.max;
    end
  end

  assign cnt_m2  = cnt_q - CW'(2);
  assign wr_addr = cnt_q[AW-1:0];
  assign rd_addr = cnt_m2[AW-1:0];

  // Next count and top cache
  always_comb begin
    cnt_d   = cnt_q;
    cache_d = cache_q;
    if (cmd_i.push) begin
      cnt_d   = cnt_q + CW'(1);
      cache_d = new_entry;
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.fill) begin
      cache_d = rd_q;
    end
  end

  assign empty_d = (cnt_d == '0);

  // Entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= new_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Top cache and result word
  always_ff @(posedge clk_i) begin
    cache_q <= cache_d;
    if (cmd_i.out_load) begin
      top_value_o <= empty_d ? mmts_pkg::EMPTY_WORD : cache_d.value;
      min_value_o <= empty_d ? mmts_pkg::EMPTY_WORD : cache_d.min;
      max_value_o <= empty_d ? mmts_pkg::EMPTY_WORD : cache_d.max;
      is_empty_o  <= empty_d;
      depth_now_o <= mmts_pkg::DEPTH_W'(cnt_d);
      status_o    <= cmd_i.status;
    end
  end

endmodule

>>> rtl/core/min_max_tracking_stack_core.sv
// Min/max tracking stack, top level.
// Input word: action_i (0 push, 1 pop, 2 or 3 read) with value_i, taken when
// in_valid_i is high and in_stall_o is low. Output word: top, minimum and
// maximum after the operation (-1 each when empty), is_empty_o, depth_now_o
// and status_o (0 ok, 1 push dropped when full, 2 pop on empty), taken when
// out_valid_o is high and out_stall_i is low.
// The result word is registered on acceptance, except for a pop that leaves
// at least one entry behind: the new top is then read from the entry memory
// through its registered read port before the result word is registered.
// Push, read and pops to empty take one word per cycle unless the receiver
// stalls; a pop that refills the top-of-stack cache holds off the next word.
// A new word is accepted while the previous result is drained in the same
// cycle; when the receiver stalls with a result pending, in_stall_o rises and
// the result holds. Reset empties the stack and clears the output valid; no
// clearing pass is needed because only entries below the count are read.
module min_max_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           action_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mmts_pkg::DATA_W-1:0]   top_value_o,
  output logic signed [mmts_pkg::DATA_W-1:0]   min_value_o,
  output logic signed [mmts_pkg::DATA_W-1:0]   max_value_o,
  output logic                                 is_empty_o,
  output logic [mmts_pkg::DEPTH_W-1:0]         depth_now_o,
  output logic [1:0]                           status_o
);

  mmts_pkg::cmd_t cmd;
  mmts_pkg::sts_t dp_sts;

  mmts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (cmd)
  );

  mmts_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .sts_o       (dp_sts),
    .top_value_o (top_value_o),
    .min_value_o (min_value_o),
    .max_value_o (max_value_o),
    .is_empty_o  (is_empty_o),
    .depth_now_o (depth_now_o),
    .status_o    (status_o)
  );

  // A pop that uncovers a stored entry holds off input for the refill cycle
  a_pop_refill_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == mmts_pkg::ACT_POP && dp_sts.two_plus)
    |=> (in_stall_o && !out_valid_o))
    else $error("pop with refill did not stall for one cycle");

  // Empty result reports -1 for top, min and max, and a depth of zero
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |->
    (top_value_o == mmts_pkg::EMPTY_WORD && min_value_o == mmts_pkg::EMPTY_WORD &&
     max_value_o == mmts_pkg::EMPTY_WORD && depth_now_o == '0))
    else $error("empty result word carries data");

  // Non-empty result keeps min <= top <= max
  a_min_top_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |->
    (min_value_o <= top_value_o && top_value_o <= max_value_o))
    else $error("running min/max inconsistent with top");

  // Overflow is only reported with a full stack, underflow with an empty one
  a_status_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
    ((status_o != mmts_pkg::STS_OVERFLOW ||
      depth_now_o == mmts_pkg::DEPTH_W'(STACK_DEPTH)) &&
     (status_o != mmts_pkg::STS_UNDERFLOW || is_empty_o)))
    else $error("status code inconsistent with depth");

endmodule

>>> dv/min_max_tracking_stack_checker.sv
// Checker for the min/max tracking stack: watches both channels, predicts
// each result word from the accepted input words and compares field by field.
// Depends on mmts_pkg for action, status and empty-word constants.
module min_max_tracking_stack_checker #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [1:0]                          action_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]  value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]  top_value_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]  min_value_i,
  input  logic signed [mmts_pkg::DATA_W-1:0]  max_value_i,
  input  logic                                is_empty_i,
  input  logic [mmts_pkg::DEPTH_W-1:0]        depth_now_i,
  input  logic [1:0]                          status_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o,
  output int unsigned                         results_o,
  output int unsigned                         overflows_o,
  output int unsigned                         underflows_o,
  output int unsigned                         peak_depth_o
);

  // What the stack should report after one operation
  typedef struct packed {
    logic signed [mmts_pkg::DATA_W-1:0] top;
    logic signed [mmts_pkg::DATA_W-1:0] lo;
    logic signed [mmts_pkg::DATA_W-1:0] hi;
    logic                               empty;
    logic [mmts_pkg::DEPTH_W-1:0]       depth;
    logic [1:0]                         status;
  } stack_view_t;

  // Shadow copy of the stack contents and running min/max per depth
  logic signed [mmts_pkg::DATA_W-1:0] shadow_vals [STACK_DEPTH];
  logic signed [mmts_pkg::DATA_W-1:0] shadow_mins [STACK_DEPTH];
  logic signed [mmts_pkg::DATA_W-1:0] shadow_maxs [STACK_DEPTH];
  int unsigned                        shadow_level;
  stack_view_t                        expected_views [$];

  // Apply one operation to the shadow stack and queue the view it leaves
  task automatic apply_stack_op(input logic [1:0] act,
                                input logic signed [mmts_pkg::DATA_W-1:0] val);
    stack_view_t                        view;
    logic signed [mmts_pkg::DATA_W-1:0] lo;
    logic signed [mmts_pkg::DATA_W-1:0] hi;
    view.status = mmts_pkg::STS_OK;
    if (act == mmts_pkg::ACT_PUSH) begin
      if (shadow_level >= STACK_DEPTH) begin
        view.status = mmts_pkg::STS_OVERFLOW;
        overflows_o++;
      end else begin
        lo = val;
        hi = val;
        if (shadow_level > 0) begin
          if (shadow_mins[shadow_level-1] < val) lo = shadow_mins[shadow_level-1];
          if (shadow_maxs[shadow_level-1] > val) hi = shadow_maxs[shadow_level-1];
        end
        shadow_vals[shadow_level] = val;
        shadow_mins[shadow_level] = lo;
        shadow_maxs[shadow_level] = hi;
        shadow_level++;
      end
    end else if (act == mmts_pkg::ACT_POP) begin
      if (shadow_level == 0) begin
        view.status = mmts_pkg::STS_UNDERFLOW;
        underflows_o++;
      end else begin
        shadow_level--;
      end
    end
    // Codes other than push and pop only read
    if (shadow_level == 0) begin
      view.top   = mmts_pkg::EMPTY_WORD;
      view.lo    = mmts_pkg::EMPTY_WORD;
      view.hi    = mmts_pkg::EMPTY_WORD;
      view.empty = 1'b1;
    end else begin
      view.top   = shadow_vals[shadow_level-1];
      view.lo    = shadow_mins[shadow_level-1];
      view.hi    = shadow_maxs[shadow_level-1];
      view.empty = 1'b0;
    end
    view.depth = shadow_level[mmts_pkg::DEPTH_W-1:0];
    if (shadow_level > peak_depth_o) peak_depth_o = shadow_level;
    expected_views.push_back(view);
  endtask

  task automatic check_field(input string name, input logic [mmts_pkg::DATA_W-1:0] want,
                             input logic [mmts_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      mismatches_o++;
    end
  endtask

  // Outputs first: a word accepted now belongs to an earlier input word
  always @(posedge clk_i or negedge rst_ni) begin
    stack_view_t want;
    if (!rst_ni) begin
      shadow_level = 0;
      expected_views.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
      overflows_o  = 0;
      underflows_o = 0;
      peak_depth_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_views.size() == 0) begin
          $display("%0t: result word with none expected: top %0d depth %0d status %0d",
                   $time, top_value_i, depth_now_i, status_i);
          mismatches_o++;
        end else begin
          want = expected_views.pop_front();
          check_field("top_value", want.top, top_value_i);
          check_field("min_value", want.lo, min_value_i);
          check_field("max_value", want.hi, max_value_i);
          check_field("is_empty", {31'd0, want.empty}, {31'd0, is_empty_i});
          check_field("depth_now", {24'd0, want.depth}, {24'd0, depth_now_i});
          check_field("status", {30'd0, want.status}, {30'd0, status_i});
        end
      end
      if (in_valid_i && !in_stall_i) apply_stack_op(action_i, value_i);
      pending_o = $unsigned(expected_views.size());
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the min/max tracking stack testbench: clock, reset, stimulus with
// bursty input and patterned output stall, watchdog and verdict.
// Depends on mmts_pkg, min_max_tracking_stack_core and the checker module.
module testbench;

  localparam int unsigned STACK_DEPTH  = 128;
  localparam int unsigned RANDOM_WORDS = 1725;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam logic [1:0]  ACT_SPARE    = 2'd3;  // unused code, acts as a read

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [1:0]                         action;
  logic signed [mmts_pkg::DATA_W-1:0] value;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [mmts_pkg::DATA_W-1:0] top_value;
  logic signed [mmts_pkg::DATA_W-1:0] min_value;
  logic signed [mmts_pkg::DATA_W-1:0] max_value;
  logic                               is_empty;
  logic [mmts_pkg::DEPTH_W-1:0]       depth_now;
  logic [1:0]                         status;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned overflows;
  int unsigned underflows;
  int unsigned peak_depth;

  // Stimulus-side bookkeeping, only used to shape the sequences
  int unsigned                        stim_depth;
  int unsigned                        burst_left;
  int unsigned                        words_sent;
  logic signed [mmts_pkg::DATA_W-1:0] last_pushed;

  min_max_tracking_stack_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .top_value_o (top_value),
    .min_value_o (min_value),
    .max_value_o (max_value),
    .is_empty_o  (is_empty),
    .depth_now_o (depth_now),
    .status_o    (status)
  );

  min_max_tracking_stack_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .top_value_i  (top_value),
    .min_value_i  (min_value),
    .max_value_i  (max_value),
    .is_empty_i   (is_empty),
    .depth_now_i  (depth_now),
    .status_i     (status),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .overflows_o  (overflows),
    .underflows_o (underflows),
    .peak_depth_o (peak_depth)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pick a value: extremes, a tight range for ties, repeats, or anything
  function automatic logic signed [mmts_pkg::DATA_W-1:0] pick_value();
    logic signed [mmts_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'sh7fff_ffff;
      1:       v = 32'sh8000_0000;
      2:       v = $signed($urandom_range(0, 8)) - 32'sd4;
      3:       v = last_pushed;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Drive one word at the falling edge and hold it until accepted
  task automatic send_word(input logic [1:0] act,
                           input logic signed [mmts_pkg::DATA_W-1:0] val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (act == mmts_pkg::ACT_PUSH) begin
      last_pushed = val;
      if (stim_depth < STACK_DEPTH) stim_depth++;
    end else if (act == mmts_pkg::ACT_POP && stim_depth > 0) begin
      stim_depth--;
    end
    words_sent++;
  endtask

  // Receiver stall: stretches of no stall, light, heavy and periodic stall
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_stall = 1'b0;
    tick      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 9) < 3);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog: too many cycles without a word moving on either side
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned run;
    int unsigned r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    action      = mmts_pkg::ACT_READ;
    value       = '0;
    stim_depth  = 0;
    burst_left  = 0;
    words_sent  = 0;
    last_pushed = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty reads and underflow, extremes, ties, spare code, drain
    send_word(mmts_pkg::ACT_READ, 32'sh1234_5678);
    send_word(mmts_pkg::ACT_POP, '0);
    send_word(ACT_SPARE, 32'sh8000_0000);
    send_word(mmts_pkg::ACT_PUSH, 32'sh7fff_ffff);
    send_word(mmts_pkg::ACT_PUSH, 32'sh8000_0000);
    send_word(mmts_pkg::ACT_PUSH, 32'sd0);
    send_word(mmts_pkg::ACT_PUSH, -32'sd1);
    send_word(mmts_pkg::ACT_PUSH, -32'sd1);
    send_word(mmts_pkg::ACT_PUSH, 32'sh8000_0000);
    send_word(mmts_pkg::ACT_PUSH, 32'sh7fff_ffff);
    send_word(ACT_SPARE, -32'sd1);
    send_word(mmts_pkg::ACT_READ, 32'sh5555_5555);
    repeat (7) send_word(mmts_pkg::ACT_POP, 32'shffff_ffff);
    send_word(mmts_pkg::ACT_POP, '0);
    send_word(mmts_pkg::ACT_PUSH, 32'sd5);
    send_word(mmts_pkg::ACT_POP, '0);
    send_word(mmts_pkg::ACT_READ, '0);
    words_sent = 0;

    // Random: mixed walks, fills past full, drains past empty, noise
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        run = $urandom_range(10, 60);
        repeat (run) begin
          r = $urandom_range(0, 99);
          if (r < 50)      send_word(mmts_pkg::ACT_PUSH, pick_value());
          else if (r < 85) send_word(mmts_pkg::ACT_POP, $urandom);
          else if (r < 95) send_word(mmts_pkg::ACT_READ, $urandom);
          else             send_word(ACT_SPARE, $urandom);
        end
      end else if (pick <= 6) begin
        while (stim_depth < STACK_DEPTH) send_word(mmts_pkg::ACT_PUSH, pick_value());
        repeat ($urandom_range(1, 4)) send_word(mmts_pkg::ACT_PUSH, pick_value());
      end else if (pick <= 8) begin
        while (stim_depth > 0) send_word(mmts_pkg::ACT_POP, $urandom);
        repeat ($urandom_range(1, 3)) send_word(mmts_pkg::ACT_POP, $urandom);
      end else begin
        repeat ($urandom_range(3, 10)) send_word(2'($urandom_range(0, 3)), $urandom);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run covered %0d result words, peak depth %0d of %0d.",
             results, peak_depth, STACK_DEPTH);
    $display("Dropped pushes on a full stack: %0d, pops on an empty one: %0d.",
             overflows, underflows);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
